// ----- sv/dmls_pkg.sv -----
// Shared types and constants for the data memory load/store unit.
// Depends on nothing; imported by dmls_check, the top level and the bench.
package dmls_pkg;

  // Data memory size in bytes and its organization as four byte lanes.
  localparam int MEM_BYTES = 1024;
  localparam int LANES     = 4;
  localparam int ROWS      = (MEM_BYTES + LANES - 1) / LANES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [3:0] {
    OP_LW   = 4'd0,
    OP_LH   = 4'd1,
    OP_LHU  = 4'd2,
    OP_LB   = 4'd3,
    OP_LBU  = 4'd4,
    OP_SW   = 4'd5,
    OP_SH   = 4'd6,
    OP_SB   = 4'd7,
    OP_NONE = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WAIT
  } st_e;

  // Decode and check result for one access.
  typedef struct packed {
    logic              access;   // memory is touched by this item
    logic              ovf;
    logic              mis;
    logic              halt;     // sticky halt flag after this item
    logic [LANES-1:0]  lane_we;  // lane 0 holds the lowest (most significant) byte
    logic [ROW_W-1:0]  row;
  } check_t;

endpackage

// ----- sv/dmls_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module dmls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dmls_check.sv -----
// Access decode: size, range and alignment checks, halt update, lane
// write enables and big-endian store data. Depends on dmls_pkg.
module dmls_check (
  input  logic [3:0]                       operation_i,
  input  logic [31:0]                      address_i,
  input  logic [31:0]                      store_data_i,
  input  logic                             halt_i,
  output dmls_pkg::check_t                 chk_o,
  output logic [dmls_pkg::LANES-1:0][7:0]  lane_wdata_o
);
  import dmls_pkg::*;

  logic [2:0]  size;
  logic        is_store;
  logic [31:0] end_addr;
  logic        ovf;
  logic        mis;
  logic        halt;

  always_comb begin
    size     = 3'd0;
    is_store = 1'b0;
    case (operation_i)
      OP_LW:         size = 3'd4;
      OP_SW:         begin size = 3'd4; is_store = 1'b1; end
      OP_LH, OP_LHU: size = 3'd2;
      OP_SH:         begin size = 3'd2; is_store = 1'b1; end
      OP_LB, OP_LBU: size = 3'd1;
      OP_SB:         begin size = 3'd1; is_store = 1'b1; end
      default:       size = 3'd0;
    endcase
  end

  assign end_addr = {1'b0, address_i[30:0]} + {29'd0, size};

  always_comb begin
    ovf = 1'b0;
    mis = 1'b0;
    if (size != 3'd0) begin
      ovf = address_i[31] | (end_addr > 32'(MEM_BYTES));
      case (size)
        3'd4:    mis = |address_i[1:0];
        3'd2:    mis = address_i[0];
        default: mis = 1'b0;
      endcase
    end
  end

  assign halt = halt_i | ovf | mis;

  always_comb begin
    chk_o        = '0;
    chk_o.access = (size != 3'd0) & ~halt;
    chk_o.ovf    = ovf;
    chk_o.mis    = mis;
    chk_o.halt   = halt;
    chk_o.row    = address_i[ROW_W+1:2];
    if (chk_o.access && is_store) begin
      case (size)
        3'd4:    chk_o.lane_we = '1;
        3'd2:    chk_o.lane_we = address_i[1] ? 4'b1100 : 4'b0011;
        default: chk_o.lane_we = 4'b0001 << address_i[1:0];
      endcase
    end
  end

  // Lane l holds byte address 4*row + l; lane 0 is the most significant.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (size)
        3'd4:    lane_wdata_o[l] = store_data_i[31-8*l -: 8];
        3'd2:    lane_wdata_o[l] = l[0] ? store_data_i[7:0] : store_data_i[15:8];
        default: lane_wdata_o[l] = store_data_i[7:0];
      endcase
    end
  end

endmodule

// ----- sv/data_memory_load_store_unit.sv -----
// Top level of the data memory load/store unit.
// Depends on dmls_pkg, dmls_check and dmls_ram.

// Memory stage of a MIPS-style pipeline over a big-endian byte memory of
// MEM_BYTES bytes, held as four byte-lane RAMs of MEM_BYTES/4 rows each.
// After reset the unit runs a clearing pass over all rows with in_ready_o
// low. For each transfer, the accept cycle checks the access, issues the
// RAM read and performs any store; the next cycle gets the registered RAM
// data, extends it and loads the output register. A new item is taken
// while the output register still holds a result, as long as that result
// is taken in the same cycle. Out-of-range or misaligned accesses raise
// their flag and set a sticky halt; from then on memory is neither read
// nor written and load_value_o is zero. Operation codes 8-15 do nothing
// and report no errors.
module data_memory_load_store_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         operation_i,
  input  logic signed [31:0] address_i,
  input  logic signed [31:0] store_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] load_value_o,
  output logic               address_overflow_o,
  output logic               misaligned_o,
  output logic               halted_o
);
  import dmls_pkg::*;

  st_e               state_q, state_d;
  logic [ROW_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic              halt_q;
  logic              in_xfer;

  check_t                  chk;
  logic [LANES-1:0][7:0]   lane_wdata;
  logic [LANES-1:0][7:0]   ram_wdata;
  logic [LANES-1:0][7:0]   ram_rdata;
  logic [LANES-1:0]        ram_we;
  logic [ROW_W-1:0]        ram_addr;

  // Pending item between accept and result
  logic              p_access_q;
  logic [3:0]        p_op_q;
  logic [1:0]        p_lane_q;
  logic              p_ovf_q, p_mis_q, p_halt_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [31:0]       load_value_q;
  logic              ovf_q, mis_q, halted_q;
  logic [31:0]       load_value;
  logic [15:0]       half;
  logic [7:0]        byte_sel;

  dmls_check u_check (
    .operation_i  (operation_i),
    .address_i    (address_i),
    .store_data_i (store_data_i),
    .halt_i       (halt_q),
    .chk_o        (chk),
    .lane_wdata_o (lane_wdata)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    dmls_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[l]),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata[l]),
      .rdata_o (ram_rdata[l])
    );
  end

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  // RAM port: clearing sweep, else the incoming access
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_addr  = clr_cnt_q;
      ram_we    = '1;
      ram_wdata = '0;
    end else begin
      ram_addr  = chk.row;
      ram_we    = in_xfer ? chk.lane_we : '0;
      ram_wdata = lane_wdata;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ROW_W'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Extend the registered read data
  always_comb begin
    half       = p_lane_q[1] ? {ram_rdata[2], ram_rdata[3]} : {ram_rdata[0], ram_rdata[1]};
    byte_sel   = ram_rdata[p_lane_q];
    load_value = '0;
    if (p_access_q) begin
      case (p_op_q)
        OP_LW:   load_value = {ram_rdata[0], ram_rdata[1], ram_rdata[2], ram_rdata[3]};
        OP_LH:   load_value = {{16{half[15]}}, half};
        OP_LHU:  load_value = {16'd0, half};
        OP_LB:   load_value = {{24{byte_sel[7]}}, byte_sel};
        OP_LBU:  load_value = {24'd0, byte_sel};
        default: load_value = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_WAIT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        halt_q <= chk.halt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      p_access_q <= chk.access;
      p_op_q     <= operation_i;
      p_lane_q   <= address_i[1:0];
      p_ovf_q    <= chk.ovf;
      p_mis_q    <= chk.mis;
      p_halt_q   <= chk.halt;
    end
    if (state_q == ST_WAIT) begin
      load_value_q <= load_value;
      ovf_q        <= p_ovf_q;
      mis_q        <= p_mis_q;
      halted_q     <= p_halt_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign load_value_o       = load_value_q;
  assign address_overflow_o = ovf_q;
  assign misaligned_o       = mis_q;
  assign halted_o           = halted_q;

  // Checks
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag dropped");

  a_xfer_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_WAIT)
    else $error("accepted transfer did not enter wait state");

  a_wait_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |=> out_valid_q)
    else $error("no result after wait state");

  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_q && !in_ready_o)
    else $error("handshake active during clearing pass");

  a_no_write_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |-> ram_we == '0)
    else $error("memory write outside accept cycle");

endmodule

// ----- bench/data_memory_load_store_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for data_memory_load_store_unit: directed and random
// accesses against an in-bench memory image. Depends on dmls_pkg and the top.

module data_memory_load_store_unit_tb;
  import dmls_pkg::*;

  // One expected result transfer.
  typedef struct {
    logic [31:0] value;
    logic        ovf;
    logic        mis;
    logic        halt;
  } access_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [3:0]         operation_i;
  logic signed [31:0] address_i;
  logic signed [31:0] store_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] load_value_o;
  logic               address_overflow_o;
  logic               misaligned_o;
  logic               halted_o;

  // Bench copy of the data memory and the sticky halt flag.
  logic [7:0]     mem_image [MEM_BYTES];
  logic           mem_halted;
  access_result_t access_results_q [$];
  int             mismatch_count;

  // Traffic shaping shared by the driver, the sink and the tests.
  bit send_calm;
  bit sink_calm;
  int hold_off_len;

  data_memory_load_store_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .address_i          (address_i),
    .store_data_i       (store_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .load_value_o       (load_value_o),
    .address_overflow_o (address_overflow_o),
    .misaligned_o       (misaligned_o),
    .halted_o           (halted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop, well past the slowest legal run (clearing pass included).
  initial begin
    #10_000_000;
    $display("data_memory_load_store_unit regression: fail");
    $finish;
  end

  // Bytes moved by an access; zero for no access and the unused codes.
  function automatic int unsigned access_bytes(logic [3:0] op);
    case (op)
      OP_LW, OP_SW:         return 4;
      OP_LH, OP_LHU, OP_SH: return 2;
      OP_LB, OP_LBU, OP_SB: return 1;
      default:              return 0;
    endcase
  endfunction

  // Applies one access to the memory image and returns what the stage
  // should report for it.
  function automatic access_result_t predict_memory_stage(logic [3:0] op,
                                                          logic [31:0] addr,
                                                          logic [31:0] data);
    access_result_t res;
    int unsigned    size;
    logic [31:0]    word;
    int             i;
    res  = '{value: '0, ovf: 1'b0, mis: 1'b0, halt: 1'b0};
    size = access_bytes(op);
    word = '0;
    if (size != 0) begin
      // Negative addresses and accesses running past the end are out of range.
      res.ovf = addr[31] || ({1'b0, addr} + 33'(size) > 33'(MEM_BYTES));
      res.mis = (addr & (size - 1)) != 0;
      if (res.ovf || res.mis) mem_halted = 1'b1;
      if (!mem_halted) begin
        // Big-endian: lowest address holds the most significant byte.
        for (i = 0; i < int'(size); i++) word = {word[23:0], mem_image[int'(addr) + i]};
        case (op)
          OP_LW:  res.value = word;
          OP_LH:  res.value = {{16{word[15]}}, word[15:0]};
          OP_LHU: res.value = {16'h0000, word[15:0]};
          OP_LB:  res.value = {{24{word[7]}}, word[7:0]};
          OP_LBU: res.value = {24'h000000, word[7:0]};
          default: begin
            for (i = 0; i < int'(size); i++)
              mem_image[int'(addr) + i] = data[8 * (int'(size) - 1 - i) +: 8];
          end
        endcase
      end
    end
    res.halt = mem_halted;
    return res;
  endfunction

  // Idle length: mostly short, a few long.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // In-range, aligned address: whole memory, a small hot window at the
  // bottom (so loads often hit earlier stores), or the top of memory.
  function automatic logic [31:0] pick_address(logic [3:0] op);
    int unsigned size;
    size = access_bytes(op);
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, MEM_BYTES / size - 1) * size;
      1:       return $urandom_range(0, 64 / size - 1) * size;
      default: return MEM_BYTES - 32 + $urandom_range(0, 32 / size - 1) * size;
    endcase
  endfunction

  // Offers one item and returns at the edge where it transfers. Valid is
  // only lowered when a gap precedes the item, so back-to-back items keep
  // it high; drain_pipeline lowers it after the last one.
  task automatic send_access(logic [3:0] op, logic [31:0] addr, logic [31:0] data);
    int unsigned gap;
    gap = (!send_calm && $urandom_range(0, 1) == 1) ? gap_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    address_i    <= addr;
    store_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    access_results_q.push_back(predict_memory_stage(op, addr, data));
  endtask

  // Stops offering, waits for every outstanding result, then lets the
  // pipeline settle.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (access_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: runs of ready, random stalls, and on request one long
  // hold-off counted here.
  initial begin : result_sink
    int stall_left;
    int run_left;
    stall_left  = 0;
    run_left    = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len > 0) begin
        stall_left   = hold_off_len;
        run_left     = 0;
        hold_off_len = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = gap_length();
        else run_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        run_left--;
      end
    end
  end

  // Result checker: values read here are the ones before this edge.
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (access_results_q.size() == 0) begin
        $display("%0t: result with nothing expected: value=%h ovf=%b mis=%b halt=%b",
                 $time, load_value_o, address_overflow_o, misaligned_o, halted_o);
        mismatch_count++;
      end else begin
        want = access_results_q.pop_front();
        if (load_value_o !== want.value) begin
          $display("%0t: load_value expected %h actual %h", $time, want.value, load_value_o);
          mismatch_count++;
        end
        if (address_overflow_o !== want.ovf) begin
          $display("%0t: address_overflow expected %b actual %b",
                   $time, want.ovf, address_overflow_o);
          mismatch_count++;
        end
        if (misaligned_o !== want.mis) begin
          $display("%0t: misaligned expected %b actual %b", $time, want.mis, misaligned_o);
          mismatch_count++;
        end
        if (halted_o !== want.halt) begin
          $display("%0t: halted expected %b actual %b", $time, want.halt, halted_o);
          mismatch_count++;
        end
      end
    end
  end

  // Extensions, byte order, last word/halfword, a byte in the last word, memory
  // cleared at reset, codes that do nothing. No faults here: halt is sticky.
  task automatic test_directed_access();
    send_access(OP_LW,  32'd0, 32'h0);
    send_access(OP_SW,  32'd0, 32'h8000_0001);
    send_access(OP_LW,  32'd0, 32'h0);
    send_access(OP_LH,  32'd0, 32'h0);
    send_access(OP_LHU, 32'd0, 32'h0);
    send_access(OP_LB,  32'd0, 32'h0);
    send_access(OP_LBU, 32'd0, 32'h0);
    send_access(OP_LBU, 32'd3, 32'h0);
    send_access(OP_LH,  32'd2, 32'h0);
    send_access(OP_SH,  MEM_BYTES - 2, 32'h1234_ABCD);
    send_access(OP_LHU, MEM_BYTES - 2, 32'h0);
    send_access(OP_SB,  MEM_BYTES - 4, 32'hCAFE_E5FF);
    send_access(OP_LW,  MEM_BYTES - 4, 32'h0);
    send_access(OP_LB,  MEM_BYTES - 4, 32'h0);
    send_access(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(4'd12,  32'h8000_0001, 32'h5A5A_5A5A);
    drain_pipeline();
  endtask

  // Well-formed traffic with random content, a little noise from the codes
  // that do nothing. Opens with a stretch where neither side idles.
  task automatic test_random_traffic(int count);
    logic [3:0] op;
    int         n;
    send_calm = 1'b1;
    sink_calm = 1'b1;
    for (n = 0; n < count; n++) begin
      if (n == 60) begin
        send_calm = 1'b0;
        sink_calm = 1'b0;
      end
      if ($urandom_range(0, 99) < 6) begin
        op = 4'($urandom_range(OP_NONE, 15));
        send_access(op, $urandom, $urandom);
      end else begin
        op = 4'($urandom_range(OP_LW, OP_SB));
        send_access(op, pick_address(op), $urandom);
      end
    end
    drain_pipeline();
  endtask

  // Receiver holds off for a long stretch while items keep coming; the
  // unit must fill and drop in_ready without losing anything.
  task automatic test_output_backpressure();
    logic [3:0] op;
    int         n;
    send_calm    = 1'b1;
    hold_off_len = 150;
    for (n = 0; n < 30; n++) begin
      op = 4'($urandom_range(OP_LW, OP_SB));
      send_access(op, pick_address(op), $urandom);
    end
    send_calm = 1'b0;
    drain_pipeline();
  endtask

  // Runs last: a misaligned word load sets the sticky halt, then every
  // fault kind is reported while memory stays untouched.
  task automatic test_fault_halt();
    logic [3:0]  op;
    logic [31:0] addr;
    int          n;
    send_access(OP_LW,  32'd2, 32'h0);                     // misaligned only
    send_access(OP_LW,  32'd0, 32'h0);                     // in range, reads zero
    send_access(OP_SW,  32'd8, 32'h1234_5678);
    send_access(OP_LW,  32'd8, 32'h0);
    send_access(OP_LW,  MEM_BYTES, 32'h0);                 // past the end
    send_access(OP_LH,  MEM_BYTES - 1, 32'h0);             // both flags
    send_access(OP_SB,  32'h8000_0000, 32'hFFFF_FFFF);     // negative
    send_access(OP_LW,  32'hFFFF_FFFC, 32'h0);
    send_access(OP_SH,  32'h7FFF_FFFE, 32'h0);
    send_access(OP_LHU, MEM_BYTES - 3, 32'h0);
    send_access(4'd15,  32'h8000_0003, 32'h0);
    for (n = 0; n < 40; n++) begin
      op = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 2))
        0:       addr = $urandom;
        1:       addr = $urandom_range(0, MEM_BYTES + 7);
        default: addr = {1'b1, 31'($urandom)};
      endcase
      send_access(op, addr, $urandom);
    end
    drain_pipeline();
  endtask

  initial begin
    mismatch_count = 0;
    mem_halted     = 1'b0;
    send_calm      = 1'b0;
    sink_calm      = 1'b0;
    hold_off_len   = 0;
    for (int i = 0; i < MEM_BYTES; i++) mem_image[i] = 8'h00;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= OP_NONE;
    address_i    <= '0;
    store_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // The clearing pass after reset shows up as in_ready low; the driver
    // simply waits for the first transfer.
    test_directed_access();
    test_random_traffic(300);
    test_output_backpressure();
    test_fault_halt();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("data_memory_load_store_unit regression: pass");
    end else begin
      $display("data_memory_load_store_unit regression: fail");
    end
    $finish;
  end

endmodule
